// ===== hw/rtl/gpio_pkg.sv =====
// Shared types and register-map constants for the GPIO register block.
package gpio_pkg;

    localparam int unsigned MaxPins = 32;

    // Register word offsets
    localparam logic [5:0] OFS_SEL_LAST = 6'd5;
    localparam logic [5:0] OFS_SET0     = 6'd7;
    localparam logic [5:0] OFS_SET1     = 6'd8;
    localparam logic [5:0] OFS_CLR0     = 6'd10;
    localparam logic [5:0] OFS_CLR1     = 6'd11;
    localparam logic [5:0] OFS_LEV0     = 6'd13;
    localparam logic [5:0] OFS_LEV1     = 6'd14;
    localparam logic [5:0] OFS_PULL     = 6'd37;
    localparam logic [5:0] OFS_PCLK0    = 6'd38;
    localparam logic [5:0] OFS_PCLK1    = 6'd39;

    localparam logic       CMD_READ    = 1'b0;
    localparam logic       CMD_WRITE   = 1'b1;
    localparam logic [2:0] FUNC_OUTPUT = 3'd1;
    localparam logic [1:0] PULL_DOWN   = 2'd1;
    localparam logic [1:0] PULL_UP     = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [5:0]  word_offset;
        logic [31:0] write_data;
        logic [31:0] pin_levels;
    } t_gpio_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] pin_drive;
        logic [31:0] pin_output_enable;
        logic [31:0] pull_up_mask;
        logic [31:0] pull_down_mask;
        logic        bad_offset;
    } t_gpio_rsp;

    // Decoded register select
    typedef struct packed {
        logic sel;
        logic set;
        logic clr;
        logic lev;
        logic pull;
        logic pclk;
        logic bad;
    } t_gpio_dec;

endpackage

// ===== hw/rtl/gpio_stream_if.sv =====
// Valid/ready channel carrying one request or one result.
interface gpio_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/gpio_addr_decode.sv =====
// Word-offset decoder for the GPIO register map.
module gpio_addr_decode import gpio_pkg::*; (
    input  logic [5:0] i_word_offset,
    output t_gpio_dec  o_dec
);

    logic w_bank2;

    always_comb begin
        o_dec.sel  = i_word_offset <= OFS_SEL_LAST;
        o_dec.set  = i_word_offset == OFS_SET0;
        o_dec.clr  = i_word_offset == OFS_CLR0;
        o_dec.lev  = i_word_offset == OFS_LEV0;
        o_dec.pull = i_word_offset == OFS_PULL;
        o_dec.pclk = i_word_offset == OFS_PCLK0;
        // second bank has no pins behind it but is a legal offset
        w_bank2 = (i_word_offset == OFS_SET1) || (i_word_offset == OFS_CLR1) ||
                  (i_word_offset == OFS_LEV1) || (i_word_offset == OFS_PCLK1);
        o_dec.bad = !(o_dec.sel || o_dec.set || o_dec.clr || o_dec.lev ||
                      o_dec.pull || o_dec.pclk || w_bank2);
    end

endmodule

// ===== hw/rtl/gpio_register_block.sv =====
// GPIO register block: function select, set/clear latch, level, pull control.
//
// Usage:
//   i_req carries one bus access per request (cmd, word_offset, write_data,
//   pin_levels); o_rsp returns one result per request with read_data (zero on
//   writes), the output latch, output enables and the two pull masks as they
//   stand after the access, plus bad_offset for reserved offsets.
//   A request is registered on acceptance and executed once the result
//   register can take it: decode, state update and result are formed and
//   written to the result register, which drives o_rsp.valid.
//   Throughput is one request per cycle while the receiver takes results;
//   the input register and the result register form a two-entry pipeline,
//   so a new request is taken while a result waits.
//   When the receiver stalls, the result holds and the pending request stays
//   in the input register; i_req.ready drops only once both are full.
//   Reset (synchronous, active low) empties both registers, sets every pin to
//   input, clears the output latch, the pull control and every pin's pull.
//   Pins at or above NUM_PINS read as zero and ignore writes.
module gpio_register_block import gpio_pkg::*; #(
    parameter int NUM_PINS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gpio_stream_if.sink   i_req,
    gpio_stream_if.source o_rsp
);

    localparam logic [31:0] PinMask = 32'((64'd1 << NUM_PINS) - 64'd1);

    logic        r_req_vld;
    t_gpio_req   r_req;
    logic        r_rsp_vld;
    t_gpio_rsp   r_rsp;
    logic [2:0]  r_func [NUM_PINS];
    logic [1:0]  r_pull [NUM_PINS];
    logic [31:0] r_latch;
    logic [1:0]  r_pull_ctl;

    logic [2:0]  n_func [NUM_PINS];
    logic [1:0]  n_pull [NUM_PINS];
    logic [31:0] n_latch;
    logic [1:0]  n_pull_ctl;
    t_gpio_rsp   n_rsp;

    logic        w_advance;
    logic        w_wr;
    t_gpio_dec   w_dec;
    logic [31:0] w_data_m;
    logic [31:0] w_sel_part [NUM_PINS];
    logic [31:0] w_sel_rd;
    logic [31:0] w_rd;

    gpio_addr_decode u_decode (
        .i_word_offset (r_req.word_offset),
        .o_dec         (w_dec)
    );

    assign w_advance   = r_req_vld && (!r_rsp_vld || o_rsp.ready);
    assign i_req.ready = !r_req_vld || w_advance;
    assign o_rsp.valid = r_rsp_vld;
    assign o_rsp.data  = r_rsp;

    assign w_wr     = r_req.cmd == CMD_WRITE;
    assign w_data_m = r_req.write_data & PinMask;

    // Per-pin select field and pull update
    for (genvar p = 0; p < NUM_PINS; p++) begin : g_pin
        localparam int Word  = p / 10;
        localparam int Field = p % 10;

        assign n_func[p] = (w_wr && w_dec.sel && r_req.word_offset == 6'(Word))
                         ? r_req.write_data[3*Field +: 3] : r_func[p];
        assign w_sel_part[p] = (r_req.word_offset == 6'(Word))
                             ? (32'(r_func[p]) << (3 * Field)) : 32'd0;
        assign n_pull[p] = (w_wr && w_dec.pclk && r_req.write_data[p])
                         ? r_pull_ctl : r_pull[p];
    end

    always_comb begin
        w_sel_rd = '0;
        for (int p = 0; p < NUM_PINS; p++) begin
            w_sel_rd = w_sel_rd | w_sel_part[p];
        end
    end

    always_comb begin
        n_latch = r_latch;
        if (w_wr && w_dec.set) begin
            n_latch = r_latch | w_data_m;
        end else if (w_wr && w_dec.clr) begin
            n_latch = r_latch & ~w_data_m;
        end
        n_pull_ctl = (w_wr && w_dec.pull) ? r_req.write_data[1:0] : r_pull_ctl;
    end

    always_comb begin
        priority if (w_dec.sel) begin
            w_rd = w_sel_rd;
        end else if (w_dec.lev) begin
            w_rd = r_req.pin_levels & PinMask;
        end else if (w_dec.pull) begin
            w_rd = {30'd0, r_pull_ctl};
        end else begin
            w_rd = '0;
        end
    end

    always_comb begin
        n_rsp                   = '0;
        n_rsp.read_data         = w_wr ? 32'd0 : w_rd;
        n_rsp.pin_drive         = n_latch;
        n_rsp.bad_offset        = w_dec.bad;
        for (int p = 0; p < NUM_PINS; p++) begin
            n_rsp.pin_output_enable[p] = n_func[p] == FUNC_OUTPUT;
            n_rsp.pull_up_mask[p]      = n_pull[p] == PULL_UP;
            n_rsp.pull_down_mask[p]    = n_pull[p] == PULL_DOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld  <= 1'b0;
            r_rsp_vld  <= 1'b0;
            r_latch    <= '0;
            r_pull_ctl <= '0;
            for (int p = 0; p < NUM_PINS; p++) begin
                r_func[p] <= '0;
                r_pull[p] <= '0;
            end
        end else begin
            // take a new request whenever the input register frees up
            if (i_req.valid && i_req.ready) begin
                r_req_vld <= 1'b1;
            end else if (w_advance) begin
                r_req_vld <= 1'b0;
            end
            if (w_advance) begin
                r_rsp_vld  <= 1'b1;
                r_latch    <= n_latch;
                r_pull_ctl <= n_pull_ctl;
                for (int p = 0; p < NUM_PINS; p++) begin
                    r_func[p] <= n_func[p];
                    r_pull[p] <= n_pull[p];
                end
            end else if (o_rsp.ready) begin
                r_rsp_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= i_req.data;
        end
        if (w_advance) begin
            r_rsp <= n_rsp;
        end
    end

endmodule
